// ----- hw/rtl/line_sensor_pid_motor_drive_unit_macros.svh -----
// Assertion macros for the line sensor PID motor drive unit.
// Depends on nothing; included by the top level only.
`ifndef LINE_SENSOR_PID_MOTOR_DRIVE_UNIT_MACROS_SVH
`define LINE_SENSOR_PID_MOTOR_DRIVE_UNIT_MACROS_SVH

// same-cycle implication
`define LSPID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lspid_pkg.sv -----
// Shared types and constants for the line sensor PID motor drive unit.
// Depends on nothing; used by lspid_clamp, the top level and the bench.
package lspid_pkg;

   localparam int SPEED_W = 16;
   localparam int ERR_W   = 4;

   typedef enum logic [2:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_BASE_SPEED  = 3'd3,
      CSR_SPEED_UPPER = 3'd4,
      CSR_SPEED_LOWER = 3'd5
   } csr_idx_type;

   localparam logic [SPEED_W-1:0] GAIN_P_RST      = 16'd2250;
   localparam logic [SPEED_W-1:0] GAIN_I_RST      = 16'd0;
   localparam logic [SPEED_W-1:0] GAIN_D_RST      = 16'd650;
   localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 16'd10000;
   localparam logic [SPEED_W-1:0] SPEED_UPPER_RST = 16'd15999;
   localparam logic [SPEED_W-1:0] SPEED_LOWER_RST = 16'd6500;

   localparam logic [7:0] PAT_CENTRE  = 8'h11;
   localparam logic [7:0] PAT_RIGHT_1 = 8'h18;
   localparam logic [7:0] PAT_RIGHT_2 = 8'h1C;
   localparam logic [7:0] PAT_RIGHT_4 = 8'h1E;
   localparam logic [7:0] PAT_LEFT_1  = 8'h03;
   localparam logic [7:0] PAT_LEFT_2  = 8'h07;
   localparam logic [7:0] PAT_LEFT_3  = 8'h0F;

   typedef struct packed {
      logic                    known;
      logic signed [ERR_W-1:0] err;
   } pattern_type;

   function automatic pattern_type map_pattern(input logic [7:0] bits);
      pattern_type r;
      r.known = 1'b1;
      case (bits)
         PAT_CENTRE:  r.err = 4'sd0;
         PAT_RIGHT_1: r.err = 4'sd1;
         PAT_RIGHT_2: r.err = 4'sd2;
         PAT_RIGHT_4: r.err = 4'sd4;
         PAT_LEFT_1:  r.err = -4'sd1;
         PAT_LEFT_2:  r.err = -4'sd2;
         PAT_LEFT_3:  r.err = -4'sd3;
         default: begin
            r.known = 1'b0;
            r.err   = 4'sd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/line_sensor_pid_motor_drive_unit.sv -----
// Line sensor PID motor drive unit: an accepted req beat passes the stage 1, stage 2
// and output registers to rsp_valid; throughput one beat per cycle while rsp_stall stays low.
// Stages: error map and integral update, three gain multiplies, PID sum and clamp.
// Synchronous reset clears gains to defaults, held error and integral to zero,
// and empties the pipeline. Depends on lspid_pkg, lspid_clamp and the macros header.
`include "line_sensor_pid_motor_drive_unit_macros.svh"

module line_sensor_pid_motor_drive_unit #(
   parameter int SUM_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_sensor_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lspid_pkg::SPEED_W-1:0]       rsp_left_match,
   output logic [lspid_pkg::SPEED_W-1:0]       rsp_right_match,
   output logic signed [lspid_pkg::ERR_W-1:0]  rsp_line_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [lspid_pkg::SPEED_W-1:0]       csr_data
);

   localparam int SW      = lspid_pkg::SPEED_W;
   localparam int EW      = lspid_pkg::ERR_W;
   localparam int DW      = EW + 1;
   localparam int PROD_P_W = SW + 1 + EW;
   localparam int PROD_D_W = SW + 1 + DW;
   localparam int PROD_I_W = SW + 1 + SUM_WIDTH;
   localparam int PID_W   = PROD_I_W + 2;
   localparam int VAL_W   = PID_W + 1;

   logic [SW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SW-1:0] base_speed_ff, speed_upper_ff, speed_lower_ff;

   logic signed [EW-1:0]        held_error_ff, held_error_in;
   logic signed [SUM_WIDTH-1:0] error_sum_ff, error_sum_in;

   logic                        s1_v_ff, s2_v_ff, rsp_valid_ff;
   logic signed [EW-1:0]        s1_err_ff;
   logic signed [DW-1:0]        s1_deriv_ff, deriv_in;
   logic signed [SUM_WIDTH-1:0] s1_sum_ff;
   logic signed [EW-1:0]        s2_err_ff;
   logic signed [PROD_P_W-1:0]  s2_p_ff, p_in;
   logic signed [PROD_D_W-1:0]  s2_d_ff, d_in;
   logic signed [PROD_I_W-1:0]  s2_i_ff, i_in;
   logic [SW-1:0]               left_ff, right_ff, left_in, right_in;
   logic signed [EW-1:0]        err_out_ff;

   logic                        adv_out, adv2, adv1, accept;
   lspid_pkg::pattern_type      pat;
   logic signed [SUM_WIDTH:0]   sum_ext;
   logic signed [PID_W-1:0]     pid;
   logic signed [VAL_W-1:0]     base_v, left_v, right_v;

   // handshake
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv2      = !s2_v_ff || adv_out;
   assign adv1      = !s1_v_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;
   assign csr_ready = 1'b1;

   // stage 1: error map, derivative, saturating integral
   assign pat           = lspid_pkg::map_pattern(req_sensor_bits);
   assign held_error_in = pat.known ? pat.err : held_error_ff;
   assign deriv_in      = {held_error_in[EW-1], held_error_in}
                        - {held_error_ff[EW-1], held_error_ff};
   assign sum_ext       = {error_sum_ff[SUM_WIDTH-1], error_sum_ff}
                        + {{(SUM_WIDTH+1-EW){held_error_in[EW-1]}}, held_error_in};

   always_comb begin
      if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
         error_sum_in = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         error_sum_in = sum_ext[SUM_WIDTH-1:0];
      end
   end

   // stage 2: gain products
   assign p_in = $signed({1'b0, gain_p_ff}) * s1_err_ff;
   assign d_in = $signed({1'b0, gain_d_ff}) * s1_deriv_ff;
   assign i_in = $signed({1'b0, gain_i_ff}) * s1_sum_ff;

   // stage 3: PID sum and motor values
   assign pid = {{(PID_W-PROD_P_W){s2_p_ff[PROD_P_W-1]}}, s2_p_ff}
              + {{(PID_W-PROD_D_W){s2_d_ff[PROD_D_W-1]}}, s2_d_ff}
              + {{(PID_W-PROD_I_W){s2_i_ff[PROD_I_W-1]}}, s2_i_ff};
   assign base_v  = $signed({{(VAL_W-SW){1'b0}}, base_speed_ff});
   assign left_v  = base_v - {pid[PID_W-1], pid};
   assign right_v = base_v + {pid[PID_W-1], pid};

   lspid_clamp #(.VAL_W(VAL_W)) u_clamp_left (
      .value  (left_v),
      .upper  (speed_upper_ff),
      .lower  (speed_lower_ff),
      .result (left_in)
   );

   lspid_clamp #(.VAL_W(VAL_W)) u_clamp_right (
      .value  (right_v),
      .upper  (speed_upper_ff),
      .lower  (speed_lower_ff),
      .result (right_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= lspid_pkg::GAIN_P_RST;
         gain_i_ff      <= lspid_pkg::GAIN_I_RST;
         gain_d_ff      <= lspid_pkg::GAIN_D_RST;
         base_speed_ff  <= lspid_pkg::BASE_SPEED_RST;
         speed_upper_ff <= lspid_pkg::SPEED_UPPER_RST;
         speed_lower_ff <= lspid_pkg::SPEED_LOWER_RST;
         held_error_ff  <= '0;
         error_sum_ff   <= '0;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (lspid_pkg::csr_idx_type'(csr_index))
               lspid_pkg::CSR_GAIN_P:      gain_p_ff      <= csr_data;
               lspid_pkg::CSR_GAIN_I:      gain_i_ff      <= csr_data;
               lspid_pkg::CSR_GAIN_D:      gain_d_ff      <= csr_data;
               lspid_pkg::CSR_BASE_SPEED:  base_speed_ff  <= csr_data;
               lspid_pkg::CSR_SPEED_UPPER: speed_upper_ff <= csr_data;
               lspid_pkg::CSR_SPEED_LOWER: speed_lower_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            held_error_ff <= held_error_in;
            error_sum_ff  <= error_sum_in;
         end
         if (adv1) begin
            s1_v_ff <= req_valid;
         end
         if (adv2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (adv_out) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_err_ff   <= held_error_in;
         s1_deriv_ff <= deriv_in;
         s1_sum_ff   <= error_sum_in;
      end
      if (adv2) begin
         s2_err_ff <= s1_err_ff;
         s2_p_ff   <= p_in;
         s2_d_ff   <= d_in;
         s2_i_ff   <= i_in;
      end
      if (adv_out) begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         err_out_ff <= s2_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_match  = left_ff;
   assign rsp_right_match = right_ff;
   assign rsp_line_error  = err_out_ff;

   `LSPID_ASSERT_IMPLY(a_full_on_stall, clock, reset, req_stall, s1_v_ff && s2_v_ff && rsp_valid_ff, "stall with a free stage")
   `LSPID_ASSERT_NEXT(a_unknown_no_deriv, clock, reset, accept && !pat.known, s1_deriv_ff == '0, "unknown pattern gave a derivative")
   `LSPID_ASSERT_IMPLY(a_held_error_range, clock, reset, held_error_ff[EW-1], held_error_ff[2:0] == 3'd5 || held_error_ff[2:0] == 3'd6 || held_error_ff[2:0] == 3'd7, "held error below -3")

endmodule

// ----- hw/rtl/lspid_clamp.sv -----
// Upper then lower clamp of a wide signed motor value to a 16-bit match value.
// Depends on lspid_pkg.
module lspid_clamp #(
   parameter int VAL_W = 44
) (
   input  logic signed [VAL_W-1:0]            value,
   input  logic [lspid_pkg::SPEED_W-1:0]      upper,
   input  logic [lspid_pkg::SPEED_W-1:0]      lower,
   output logic [lspid_pkg::SPEED_W-1:0]      result
);

   logic signed [VAL_W-1:0] up_s;
   logic signed [VAL_W-1:0] lo_s;
   logic signed [VAL_W-1:0] cut_hi;
   logic signed [VAL_W-1:0] cut_lo;

   assign up_s   = $signed({{(VAL_W-lspid_pkg::SPEED_W){1'b0}}, upper});
   assign lo_s   = $signed({{(VAL_W-lspid_pkg::SPEED_W){1'b0}}, lower});
   assign cut_hi = (value > up_s) ? up_s : value;
   assign cut_lo = (cut_hi < lo_s) ? lo_s : cut_hi;
   assign result = cut_lo[lspid_pkg::SPEED_W-1:0];

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for the line sensor PID motor drive unit: drives sensor beats and
// register writes, predicts each left/right match and line error, and checks every rsp beat.
// Depends on lspid_pkg and line_sensor_pid_motor_drive_unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int SPEED_W = lspid_pkg::SPEED_W;
   localparam int ERR_W   = lspid_pkg::ERR_W;
   localparam int SUM_W = 24;
   localparam int LIMIT = 200000;
   localparam logic [2:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [2:0] CSR_UNUSED_7 = 3'd7;
   localparam logic [7:0] line_pats [7] = '{lspid_pkg::PAT_CENTRE, lspid_pkg::PAT_RIGHT_1,
                                            lspid_pkg::PAT_RIGHT_2, lspid_pkg::PAT_RIGHT_4,
                                            lspid_pkg::PAT_LEFT_1, lspid_pkg::PAT_LEFT_2,
                                            lspid_pkg::PAT_LEFT_3};

   typedef struct {
      logic [SPEED_W-1:0]       left;
      logic [SPEED_W-1:0]       right;
      logic signed [ERR_W-1:0]  err;
   } drive_beat_type;

   class pid_drive_tracker_type;
      localparam longint SUM_MAX = (longint'(1) << (SUM_W - 1)) - 1;
      localparam longint SUM_MIN = -SUM_MAX - 1;

      logic [SPEED_W-1:0]      gain_p, gain_i, gain_d, base_speed, speed_upper, speed_lower;
      logic signed [ERR_W-1:0] held_err;
      logic signed [SUM_W-1:0] err_sum;
      drive_beat_type          due_drives[$];
      int unsigned             faults;

      function new();
         gain_p      = lspid_pkg::GAIN_P_RST;
         gain_i      = lspid_pkg::GAIN_I_RST;
         gain_d      = lspid_pkg::GAIN_D_RST;
         base_speed  = lspid_pkg::BASE_SPEED_RST;
         speed_upper = lspid_pkg::SPEED_UPPER_RST;
         speed_lower = lspid_pkg::SPEED_LOWER_RST;
         held_err    = '0;
         err_sum     = '0;
         faults      = 0;
      endfunction

      function void load_reg(logic [2:0] idx, logic [SPEED_W-1:0] val);
         case (idx)
            lspid_pkg::CSR_GAIN_P:      gain_p      = val;
            lspid_pkg::CSR_GAIN_I:      gain_i      = val;
            lspid_pkg::CSR_GAIN_D:      gain_d      = val;
            lspid_pkg::CSR_BASE_SPEED:  base_speed  = val;
            lspid_pkg::CSR_SPEED_UPPER: speed_upper = val;
            lspid_pkg::CSR_SPEED_LOWER: speed_lower = val;
            default: ;
         endcase
      endfunction

      function logic [SPEED_W-1:0] clamp_speed(longint v);
         if (v > longint'(speed_upper)) v = longint'(speed_upper);
         if (v < longint'(speed_lower)) v = longint'(speed_lower);
         return v[SPEED_W-1:0];
      endfunction

      function void note_sample(logic [7:0] bits);
         logic signed [ERR_W-1:0] err;
         longint                  acc, deriv, pid;
         drive_beat_type          want;
         case (bits)
            lspid_pkg::PAT_CENTRE:  err = 4'sd0;
            lspid_pkg::PAT_RIGHT_1: err = 4'sd1;
            lspid_pkg::PAT_RIGHT_2: err = 4'sd2;
            lspid_pkg::PAT_RIGHT_4: err = 4'sd4;
            lspid_pkg::PAT_LEFT_1:  err = -4'sd1;
            lspid_pkg::PAT_LEFT_2:  err = -4'sd2;
            lspid_pkg::PAT_LEFT_3:  err = -4'sd3;
            default:                err = held_err;
         endcase
         deriv = longint'(err) - longint'(held_err);
         acc = longint'(err_sum) + longint'(err);
         if (acc > SUM_MAX) acc = SUM_MAX;
         if (acc < SUM_MIN) acc = SUM_MIN;
         err_sum  = acc[SUM_W-1:0];
         held_err = err;
         pid = longint'(gain_p) * longint'(err) + longint'(gain_i) * acc
               + longint'(gain_d) * deriv;
         want.left  = clamp_speed(longint'(base_speed) - pid);
         want.right = clamp_speed(longint'(base_speed) + pid);
         want.err   = err;
         due_drives.push_back(want);
      endfunction

      function void check_drive(logic [SPEED_W-1:0] left, logic [SPEED_W-1:0] right,
                                logic signed [ERR_W-1:0] err);
         drive_beat_type want;
         if (due_drives.size() == 0) begin
            $error("rsp beat with no drive value due");
            faults++;
            return;
         end
         want = due_drives.pop_front();
         if (left !== want.left) begin
            $error("left_match: expected %0d, got %0d", want.left, left);
            faults++;
         end
         if (right !== want.right) begin
            $error("right_match: expected %0d, got %0d", want.right, right);
            faults++;
         end
         if (err !== want.err) begin
            $error("line_error: expected %0d, got %0d", want.err, err);
            faults++;
         end
      endfunction

      function int pending();
         return due_drives.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_sensor_bits;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [SPEED_W-1:0]       rsp_left_match;
   logic [SPEED_W-1:0]       rsp_right_match;
   logic signed [ERR_W-1:0]  rsp_line_error;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [2:0]               csr_index;
   logic [SPEED_W-1:0]       csr_data;

   pid_drive_tracker_type tracker;
   bit               calm;
   int               gap_pct;
   int               stall_pct;
   int               stall_left;
   int               cycle_count;

   line_sensor_pid_motor_drive_unit #(.SUM_WIDTH(SUM_W)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sensor_bits (req_sensor_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_match  (rsp_left_match),
      .rsp_right_match (rsp_right_match),
      .rsp_line_error  (rsp_line_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // hold rsp_stall for random bursts
   always @(posedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(99) < stall_pct)
         stall_left = $urandom_range(7, 1);
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0)
         stall_left = stall_left - 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_drive(rsp_left_match, rsp_right_match, rsp_line_error);
   end

   task automatic send_sample(input logic [7:0] bits);
      int gap;
      if (!calm && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(7, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_sample(bits);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [SPEED_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.load_reg(idx, val);
   endtask

   task automatic load_drive(input logic [SPEED_W-1:0] p, i, d, base, up, lo);
      write_reg(lspid_pkg::CSR_GAIN_P, p);
      write_reg(lspid_pkg::CSR_GAIN_I, i);
      write_reg(lspid_pkg::CSR_GAIN_D, d);
      write_reg(lspid_pkg::CSR_BASE_SPEED, base);
      write_reg(lspid_pkg::CSR_SPEED_UPPER, up);
      write_reg(lspid_pkg::CSR_SPEED_LOWER, lo);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // runs of line patterns with random content, long pushes to one side, and noise
   task automatic run_random(input int budget);
      int         sent, mode, run, k;
      logic [7:0] pat;
      sent = 0;
      while (sent < budget) begin
         mode = $urandom_range(9);
         if (mode < 3) begin
            run = $urandom_range(3, 1);
         end else if (mode == 3) begin
            pat = $urandom_range(1) ? lspid_pkg::PAT_RIGHT_4 : lspid_pkg::PAT_LEFT_3;
            run = $urandom_range(130, 30);
         end else begin
            pat = line_pats[3'($urandom_range(6))];
            run = $urandom_range(6, 1);
         end
         for (k = 0; k < run && sent < budget; k++) begin
            send_sample(mode < 3 ? 8'($urandom_range(255)) : pat);
            sent++;
         end
      end
   endtask

   initial begin
      logic [7:0]         directed [$];
      logic [SPEED_W-1:0] up;
      int                 phase;
      req_valid       <= 1'b0;
      req_sensor_bits <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= lspid_pkg::CSR_GAIN_P;
      csr_data        <= '0;
      rsp_stall       <= 1'b0;
      reset           <= 1'b1;
      calm       = 1'b0;
      gap_pct    = 0;
      stall_pct  = 0;
      stall_left = 0;
      tracker    = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every pattern, holds after unknown patterns, all-zero and all-one bytes
      directed = '{lspid_pkg::PAT_CENTRE, lspid_pkg::PAT_RIGHT_1, lspid_pkg::PAT_RIGHT_2,
                   lspid_pkg::PAT_RIGHT_4, 8'hA5, 8'h5A,
                   lspid_pkg::PAT_LEFT_1, lspid_pkg::PAT_LEFT_2, lspid_pkg::PAT_LEFT_3,
                   8'h00, 8'hFF, lspid_pkg::PAT_RIGHT_4,
                   lspid_pkg::PAT_LEFT_3, 8'h80, lspid_pkg::PAT_CENTRE, 8'h01, 8'h1F,
                   lspid_pkg::PAT_LEFT_1, 8'hE0};
      foreach (directed[n]) send_sample(directed[n]);
      drain();

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: load_drive(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000);
            1: begin
               write_reg(CSR_UNUSED_6, 16'hFFFF);
               load_drive('0, '0, '0, '0, '0, '0);
            end
            2: begin
               // lower bound above upper bound
               up = 16'($urandom_range(16'h7FFF));
               load_drive(16'($urandom_range(3000)), 16'($urandom_range(200)),
                          16'($urandom_range(3000)), 16'($urandom_range(16'hFFFF)), up,
                          16'($urandom_range(16'hFFFF, up + 1)));
            end
            3: begin
               up = 16'($urandom_range(20000, 5000));
               load_drive(16'($urandom_range(4000)), 16'($urandom_range(300, 1)),
                          16'($urandom_range(2000)), up,
                          16'($urandom_range(16'hFFFF, up)), 16'($urandom_range(up)));
            end
            4: begin
               write_reg(CSR_UNUSED_7, 16'($urandom_range(16'hFFFF)));
               load_drive(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                          16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                          16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
            end
            5: load_drive(16'($urandom_range(500)), 16'($urandom_range(100, 1)),
                          16'($urandom_range(500)), 16'hFFFF, 16'hFFFF, 16'h0000);
            default: begin
               calm = 1'b1;
               load_drive(lspid_pkg::GAIN_P_RST, 16'($urandom_range(50, 1)),
                          lspid_pkg::GAIN_D_RST, lspid_pkg::BASE_SPEED_RST,
                          lspid_pkg::SPEED_UPPER_RST, lspid_pkg::SPEED_LOWER_RST);
            end
         endcase
         gap_pct   = $urandom_range(1) ? $urandom_range(40, 5) : 0;
         stall_pct = $urandom_range(1) ? $urandom_range(40, 5) : 0;
         run_random(162);
         drain();
      end

      repeat (8) @(posedge clock);
      if (tracker.faults == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- line_sensor_pid_motor_drive_unit.f -----
+incdir+hw/rtl
hw/rtl/lspid_pkg.sv
hw/rtl/lspid_clamp.sv
hw/rtl/line_sensor_pid_motor_drive_unit.sv
test/tb_top.sv
